[design/msp_pkg.sv]
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types, widths and register codes of the motor speed PID loop.
// ----------------------------------------------------------------------------
`default_nettype none

package msp_pkg;

    // Field widths
    localparam int SPEED_W  = 16;
    localparam int GAIN_W   = 24;
    localparam int LIMIT_W  = 31;
    localparam int ERR_W    = SPEED_W + 1;
    localparam int DERIV_W  = ERR_W + 1;
    localparam int INTEG_W  = 32;
    localparam int CIDX_W   = 3;
    localparam int CDATA_W  = 31;
    localparam int DIR_W    = 2;

    // Product and sum widths (gains carry a zero sign bit)
    localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
    localparam int PROD_I_W = GAIN_W + 1 + INTEG_W;
    localparam int PROD_D_W = GAIN_W + 1 + DERIV_W;
    localparam int SUM_W    = PROD_I_W + 1;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_TARGET_SPEED   = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_GAIN_P         = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_GAIN_I         = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_GAIN_D         = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_INTEGRAL_LIMIT = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_DRIVE_MAX      = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_DRIVE_MIN      = 3'd6;

    // Direction codes
    localparam logic [DIR_W-1:0] DIR_STOP    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FORWARD = 2'd1;
    localparam logic [DIR_W-1:0] DIR_REVERSE = 2'd2;

    // Configuration register file contents
    typedef struct packed {
        logic signed [SPEED_W-1:0] target_speed;
        logic        [GAIN_W-1:0]  gain_p;
        logic        [GAIN_W-1:0]  gain_i;
        logic        [GAIN_W-1:0]  gain_d;
        logic        [LIMIT_W-1:0] integral_limit;
        logic signed [SPEED_W-1:0] drive_max;
        logic signed [SPEED_W-1:0] drive_min;
    } t_cfg;

    // Error stage result
    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [INTEG_W-1:0] integ;
        logic signed [DERIV_W-1:0] deriv;
    } t_err_data;

    // Weighted terms
    typedef struct packed {
        logic signed [PROD_P_W-1:0] p_term;
        logic signed [PROD_I_W-1:0] i_term;
        logic signed [PROD_D_W-1:0] d_term;
    } t_terms;

endpackage : msp_pkg

`default_nettype wire

[design/msp_cfg_regs.sv]
// ----------------------------------------------------------------------------
// msp_cfg_regs
// Configuration register file; unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_cfg_regs
    import msp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_wr_en,
    input  wire logic [CIDX_W-1:0]  i_wr_index,
    input  wire logic [CDATA_W-1:0] i_wr_data,
    output t_cfg                    o_cfg
);

    t_cfg r_cfg;

    // Load reset values, then take writes by index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_speed   <= 16'sd20;
            r_cfg.gain_p         <= 24'd276562;
            r_cfg.gain_i         <= 24'd49349;
            r_cfg.gain_d         <= 24'd66;
            r_cfg.integral_limit <= 31'd1000;
            r_cfg.drive_max      <= 16'sd1000;
            r_cfg.drive_min      <= -16'sd1000;
        end else if (i_wr_en) begin
            case (i_wr_index)
                CFG_TARGET_SPEED:   r_cfg.target_speed   <= i_wr_data[SPEED_W-1:0];
                CFG_GAIN_P:         r_cfg.gain_p         <= i_wr_data[GAIN_W-1:0];
                CFG_GAIN_I:         r_cfg.gain_i         <= i_wr_data[GAIN_W-1:0];
                CFG_GAIN_D:         r_cfg.gain_d         <= i_wr_data[GAIN_W-1:0];
                CFG_INTEGRAL_LIMIT: r_cfg.integral_limit <= i_wr_data[LIMIT_W-1:0];
                CFG_DRIVE_MAX:      r_cfg.drive_max      <= i_wr_data[SPEED_W-1:0];
                CFG_DRIVE_MIN:      r_cfg.drive_min      <= i_wr_data[SPEED_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule : msp_cfg_regs

`default_nettype wire

[design/msp_err_stage.sv]
// ----------------------------------------------------------------------------
// msp_err_stage
// Error, clamped integral and derivative; holds the loop state.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_err_stage
    import msp_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_adv,
    input  wire logic                      i_valid,
    input  wire logic signed [SPEED_W-1:0] i_meas,
    input  wire t_cfg                      i_cfg,
    output logic                           o_valid,
    output t_err_data                      o_data
);

    logic signed [INTEG_W-1:0] r_integ;
    logic signed [ERR_W-1:0]   r_prev_err;
    logic                      r_valid;
    t_err_data                 r_data;

    logic signed [ERR_W-1:0]   n_err;
    logic signed [DERIV_W-1:0] n_deriv;
    logic signed [INTEG_W:0]   w_integ_raw;
    logic signed [INTEG_W:0]   w_lim;
    logic signed [INTEG_W:0]   w_neg_lim;
    logic signed [INTEG_W-1:0] n_integ;

    // Form error, accumulate and clamp, difference against last error
    always_comb begin
        n_err       = {i_cfg.target_speed[SPEED_W-1], i_cfg.target_speed}
                    - {i_meas[SPEED_W-1], i_meas};
        n_deriv     = {n_err[ERR_W-1], n_err} - {r_prev_err[ERR_W-1], r_prev_err};
        w_integ_raw = {r_integ[INTEG_W-1], r_integ}
                    + {{(INTEG_W+1-ERR_W){n_err[ERR_W-1]}}, n_err};
        w_lim       = {{(INTEG_W+1-LIMIT_W){1'b0}}, i_cfg.integral_limit};
        w_neg_lim   = -w_lim;
        if (w_integ_raw > w_lim) begin
            n_integ = w_lim[INTEG_W-1:0];
        end else if (w_integ_raw < w_neg_lim) begin
            n_integ = w_neg_lim[INTEG_W-1:0];
        end else begin
            n_integ = w_integ_raw[INTEG_W-1:0];
        end
    end

    // Advance loop state only on a real request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ    <= '0;
            r_prev_err <= '0;
            r_valid    <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_integ    <= n_integ;
                r_prev_err <= n_err;
            end
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid) begin
            r_data.err   <= n_err;
            r_data.integ <= n_integ;
            r_data.deriv <= n_deriv;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule : msp_err_stage

`default_nettype wire

[design/msp_mul_stage.sv]
// ----------------------------------------------------------------------------
// msp_mul_stage
// Three gain multiplies, one per term, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_mul_stage
    import msp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_adv,
    input  wire logic      i_valid,
    input  wire t_err_data i_data,
    input  wire t_cfg      i_cfg,
    output logic           o_valid,
    output t_terms         o_terms
);

    logic                     r_valid;
    t_terms                   r_terms;
    t_terms                   n_terms;
    logic signed [GAIN_W:0]   w_gp;
    logic signed [GAIN_W:0]   w_gi;
    logic signed [GAIN_W:0]   w_gd;

    // Gains are unsigned: prepend a zero sign bit
    always_comb begin
        w_gp           = {1'b0, i_cfg.gain_p};
        w_gi           = {1'b0, i_cfg.gain_i};
        w_gd           = {1'b0, i_cfg.gain_d};
        n_terms.p_term = w_gp * i_data.err;
        n_terms.i_term = w_gi * i_data.integ;
        n_terms.d_term = w_gd * i_data.deriv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid) begin
            r_terms <= n_terms;
        end
    end

    assign o_valid = r_valid;
    assign o_terms = r_terms;

endmodule : msp_mul_stage

`default_nettype wire

[design/msp_out_stage.sv]
// ----------------------------------------------------------------------------
// msp_out_stage
// Sum of terms, floor shift, drive clamp, direction; output register.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_out_stage
    import msp_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_adv,
    input  wire logic               i_valid,
    input  wire t_terms             i_terms,
    input  wire t_cfg               i_cfg,
    output logic                    o_valid,
    output logic signed [SPEED_W-1:0] o_drive,
    output logic [DIR_W-1:0]        o_direction
);

    logic                      r_valid;
    logic signed [SPEED_W-1:0] r_drive;
    logic [DIR_W-1:0]          r_direction;

    logic signed [SUM_W-1:0]   w_sum;
    logic signed [SUM_W-1:0]   w_shifted;
    logic signed [SUM_W-1:0]   w_hi;
    logic signed [SUM_W-1:0]   w_lo;
    logic signed [SPEED_W-1:0] n_drive;
    logic [DIR_W-1:0]          n_direction;

    // Sum, shift toward minus infinity, clamp high then low
    always_comb begin
        w_sum = {{(SUM_W-PROD_P_W){i_terms.p_term[PROD_P_W-1]}}, i_terms.p_term}
              + {{(SUM_W-PROD_I_W){i_terms.i_term[PROD_I_W-1]}}, i_terms.i_term}
              + {{(SUM_W-PROD_D_W){i_terms.d_term[PROD_D_W-1]}}, i_terms.d_term};
        w_shifted = w_sum >>> GAIN_FRAC_BITS;
        w_hi      = {{(SUM_W-SPEED_W){i_cfg.drive_max[SPEED_W-1]}}, i_cfg.drive_max};
        w_lo      = {{(SUM_W-SPEED_W){i_cfg.drive_min[SPEED_W-1]}}, i_cfg.drive_min};
        // Crossed bounds: the lower clamp comes last and wins
        if (w_shifted > w_hi) begin
            n_drive = i_cfg.drive_max;
            if (w_hi < w_lo) begin
                n_drive = i_cfg.drive_min;
            end
        end else if (w_shifted < w_lo) begin
            n_drive = i_cfg.drive_min;
        end else begin
            n_drive = w_shifted[SPEED_W-1:0];
        end
        if (i_cfg.target_speed > 0) begin
            n_direction = DIR_FORWARD;
        end else if (i_cfg.target_speed < 0) begin
            n_direction = DIR_REVERSE;
        end else begin
            n_direction = DIR_STOP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid) begin
            r_drive     <= n_drive;
            r_direction <= n_direction;
        end
    end

    assign o_valid     = r_valid;
    assign o_drive     = r_drive;
    assign o_direction = r_direction;

endmodule : msp_out_stage

`default_nettype wire

[design/motor_speed_pid.sv]
// ----------------------------------------------------------------------------
// motor_speed_pid
// Positional PID speed loop: one measured speed in, one drive value out.
//
// Input channel: i_in_valid / o_in_ready carry i_measured_speed. Output
// channel: o_out_valid / i_out_ready carry o_drive and o_direction, exactly
// one result per request, in order. Configuration channel: i_cfg_valid /
// o_cfg_ready carry i_cfg_index and i_cfg_data; o_cfg_ready is always high,
// indexes 7 and up are dropped. Write configuration only while idle.
//
// The datapath is four register stages: input, error/integral, gain
// multiplies, sum/shift/clamp into the output register. One request per cycle
// is taken while the output is not stalled; the integral and previous-error
// update closes within the error stage. When the receiver stalls with a
// result held, all stages freeze and o_in_ready drops; results are never
// dropped or repeated.
// Reset (synchronous, active low) loads the register defaults, clears the
// integral and previous error and empties the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_speed_pid
    import msp_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic signed [SPEED_W-1:0] i_measured_speed,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic signed [SPEED_W-1:0]      o_drive,
    output logic [DIR_W-1:0]               o_direction,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [CIDX_W-1:0]         i_cfg_index,
    input  wire logic [CDATA_W-1:0]        i_cfg_data
);

    t_cfg                      w_cfg;
    t_err_data                 w_err_data;
    t_terms                    w_terms;
    logic                      w_adv;
    logic                      r_in_valid;
    logic signed [SPEED_W-1:0] r_meas;
    logic                      w_s2_valid;
    logic                      w_s3_valid;

    // Whole pipeline moves when the output slot is free or being drained
    assign w_adv       = !o_out_valid || i_out_ready;
    assign o_in_ready  = w_adv;
    assign o_cfg_ready = 1'b1;

    msp_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_adv) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_in_valid) begin
            r_meas <= i_measured_speed;
        end
    end

    msp_err_stage u_err (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_in_valid),
        .i_meas  (r_meas),
        .i_cfg   (w_cfg),
        .o_valid (w_s2_valid),
        .o_data  (w_err_data)
    );

    msp_mul_stage u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_s2_valid),
        .i_data  (w_err_data),
        .i_cfg   (w_cfg),
        .o_valid (w_s3_valid),
        .o_terms (w_terms)
    );

    msp_out_stage #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_valid     (w_s3_valid),
        .i_terms     (w_terms),
        .i_cfg       (w_cfg),
        .o_valid     (o_out_valid),
        .o_drive     (o_drive),
        .o_direction (o_direction)
    );

    // Requests move one stage per advancing cycle
    a_in_to_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && w_adv |=> w_s2_valid)
        else $error("request lost between input and error stage");

    a_s2_to_s3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s2_valid && w_adv |=> w_s3_valid)
        else $error("request lost between error and multiply stage");

    a_s3_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s3_valid && w_adv |=> o_out_valid)
        else $error("request lost between multiply and output stage");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule : motor_speed_pid

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the motor speed PID loop. A queue of speed
// requests and register writes feeds a clocked driver; a clocked monitor
// predicts every drive result from its own copy of the loop state and checks
// each returned result against the oldest prediction. Both sides idle in
// random bursts, and the receiver holds off once long enough to stall input.
// ----------------------------------------------------------------------------
module testbench;
    import msp_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam int TAIL_REQUESTS = 200;
    localparam int HOLD_AFTER = 750;
    localparam int HOLD_CYCLES = 120;
    localparam logic [CIDX_W-1:0] CFG_UNMAPPED = 3'd7;

    typedef struct {
        bit                        is_write;
        logic [CIDX_W-1:0]         index;
        logic [CDATA_W-1:0]        data;
        logic signed [SPEED_W-1:0] speed;
    } loop_request_t;

    typedef struct {
        logic signed [SPEED_W-1:0] drive;
        logic [DIR_W-1:0]          direction;
    } drive_result_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic signed [SPEED_W-1:0] i_measured_speed = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic signed [SPEED_W-1:0] o_drive;
    logic [DIR_W-1:0]          o_direction;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CIDX_W-1:0]         i_cfg_index = '0;
    logic [CDATA_W-1:0]        i_cfg_data = '0;

    // Stimulus and prediction state
    loop_request_t loop_req_q[$];
    drive_result_t expected_drive_q[$];
    t_cfg          loop_cfg;
    longint        integral_acc;
    longint        last_error;

    bit in_fire = 1'b0;
    bit cfg_fire = 1'b0;
    bit tail_phase = 1'b0;
    bit stall_hold = 1'b0;
    int idle_pct = 0;
    int tx_gap = 0;
    int rx_gap = 0;
    int speeds_taken = 0;
    int drives_checked = 0;
    int writes_taken = 0;
    int fail_count = 0;

    motor_speed_pid #(
        .GAIN_FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_measured_speed(i_measured_speed),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_drive         (o_drive),
        .o_direction     (o_direction),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Queue a speed request, saturated to the 16-bit range
    task automatic add_speed(input int s);
        loop_request_t req;
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
        req.is_write = 1'b0;
        req.index = '0;
        req.data = '0;
        req.speed = s[SPEED_W-1:0];
        loop_req_q.push_back(req);
    endtask

    // Queue a register write
    task automatic add_write(input logic [CIDX_W-1:0] index, input int value);
        loop_request_t req;
        req.is_write = 1'b1;
        req.index = index;
        req.data = value[CDATA_W-1:0];
        req.speed = '0;
        loop_req_q.push_back(req);
    endtask

    // Pick a gain: zero, full scale with junk above the field, or moderate
    function automatic int rand_gain();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 32'h00FF_FFFF | ($urandom_range(0, 127) << 24);
            default: return $urandom_range(0, 1 << 18);
        endcase
    endfunction

    // Apply a register write to the predicted configuration
    function automatic void apply_write(logic [CIDX_W-1:0] index,
                                        logic [CDATA_W-1:0] data);
        case (index)
            CFG_TARGET_SPEED:   loop_cfg.target_speed = data[SPEED_W-1:0];
            CFG_GAIN_P:         loop_cfg.gain_p = data[GAIN_W-1:0];
            CFG_GAIN_I:         loop_cfg.gain_i = data[GAIN_W-1:0];
            CFG_GAIN_D:         loop_cfg.gain_d = data[GAIN_W-1:0];
            CFG_INTEGRAL_LIMIT: loop_cfg.integral_limit = data[LIMIT_W-1:0];
            CFG_DRIVE_MAX:      loop_cfg.drive_max = data[SPEED_W-1:0];
            CFG_DRIVE_MIN:      loop_cfg.drive_min = data[SPEED_W-1:0];
            default: ;
        endcase
    endfunction

    // Advance the loop by one sample and return the drive it produces
    function automatic drive_result_t pid_step(logic signed [SPEED_W-1:0] meas);
        drive_result_t res;
        longint tgt, err, integ, lim, sum, drv, hi, lo;
        tgt = longint'($signed(loop_cfg.target_speed));
        err = tgt - longint'(meas);
        lim = longint'(loop_cfg.integral_limit);
        hi = longint'($signed(loop_cfg.drive_max));
        lo = longint'($signed(loop_cfg.drive_min));

        // Clamp the integral after adding the new error
        integ = integral_acc + err;
        if (integ > lim) integ = lim;
        if (integ < -lim) integ = -lim;

        sum = longint'(loop_cfg.gain_p) * err + longint'(loop_cfg.gain_i) * integ
            + longint'(loop_cfg.gain_d) * (err - last_error);
        drv = sum >>> FRAC_BITS;

        // Upper clamp first, so the lower bound wins when the bounds cross
        if (drv > hi) drv = hi;
        if (drv < lo) drv = lo;

        res.drive = drv[SPEED_W-1:0];
        if (tgt > 0) res.direction = DIR_FORWARD;
        else if (tgt < 0) res.direction = DIR_REVERSE;
        else res.direction = DIR_STOP;

        integral_acc = integ;
        last_error = err;
        return res;
    endfunction

    // Monitor: record handshakes, predict on each request, check each result
    always @(posedge i_clk) begin
        drive_result_t want;
        in_fire = i_rst_n && i_in_valid && o_in_ready;
        cfg_fire = i_rst_n && i_cfg_valid && o_cfg_ready;
        if (cfg_fire) begin
            apply_write(i_cfg_index, i_cfg_data);
            writes_taken++;
        end
        if (in_fire) begin
            expected_drive_q.push_back(pid_step(i_measured_speed));
            speeds_taken++;
        end
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (expected_drive_q.size() == 0) begin
                $display("%0t: unexpected result: drive %0d direction %0d",
                         $time, o_drive, o_direction);
                fail_count++;
            end else begin
                want = expected_drive_q.pop_front();
                drives_checked++;
                if (o_drive !== want.drive) begin
                    $display("%0t: drive mismatch: expected %0d, actual %0d",
                             $time, want.drive, o_drive);
                    fail_count++;
                end
                if (o_direction !== want.direction) begin
                    $display("%0t: direction mismatch: expected %0d, actual %0d",
                             $time, want.direction, o_direction);
                    fail_count++;
                end
            end
        end
    end

    // Driver: hold each request until taken, write registers only when drained
    always @(negedge i_clk) begin
        loop_request_t req;
        logic nxt_valid, nxt_cfg_valid;
        logic signed [SPEED_W-1:0] nxt_speed;
        logic [CIDX_W-1:0] nxt_index;
        logic [CDATA_W-1:0] nxt_data;
        nxt_valid = i_in_valid && !in_fire;
        nxt_cfg_valid = i_cfg_valid && !cfg_fire;
        nxt_speed = i_measured_speed;
        nxt_index = i_cfg_index;
        nxt_data = i_cfg_data;
        tail_phase = loop_req_q.size() < TAIL_REQUESTS;
        if (in_fire && !tail_phase && $urandom_range(0, 99) < idle_pct)
            tx_gap = $urandom_range(1, 7);

        if (i_rst_n && !nxt_valid && !nxt_cfg_valid) begin
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (loop_req_q.size() > 0) begin
                if (loop_req_q[0].is_write) begin
                    if (expected_drive_q.size() == 0) begin
                        req = loop_req_q.pop_front();
                        nxt_cfg_valid = 1'b1;
                        nxt_index = req.index;
                        nxt_data = req.data;
                        case ($urandom_range(0, 3))
                            0: idle_pct = 0;
                            1: idle_pct = 10;
                            2: idle_pct = 30;
                            default: idle_pct = 60;
                        endcase
                    end
                end else begin
                    req = loop_req_q.pop_front();
                    nxt_valid = 1'b1;
                    nxt_speed = req.speed;
                end
            end
        end

        i_in_valid <= nxt_valid;
        i_measured_speed <= nxt_speed;
        i_cfg_valid <= nxt_cfg_valid;
        i_cfg_index <= nxt_index;
        i_cfg_data <= nxt_data;
    end

    // Receiver: ready with random stall bursts, none at the tail
    always @(negedge i_clk) begin
        if (stall_hold) begin
            i_out_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            i_out_ready <= 1'b0;
        end else if (!tail_phase && $urandom_range(0, 99) < idle_pct / 3) begin
            rx_gap = $urandom_range(0, 6);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Long receiver hold-off mid-run so the pipeline fills and blocks input
    initial begin
        wait (speeds_taken >= HOLD_AFTER);
        stall_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        stall_hold = 1'b0;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Build the request list, reset, then wait for the drain
    initial begin
        int tgt, s, hi, lo;
        loop_cfg = '{target_speed: 16'sd20, gain_p: 24'd276562, gain_i: 24'd49349,
                     gain_d: 24'd66, integral_limit: 31'd1000,
                     drive_max: 16'sd1000, drive_min: -16'sd1000};
        integral_acc = 0;
        last_error = 0;

        // Reset defaults: zero error, extremes of the measurement
        add_speed(20);
        add_speed(32767);
        add_speed(-32768);
        add_speed(0);
        add_speed(19);
        add_speed(21);

        // Unmapped register index is dropped
        add_write(CFG_UNMAPPED, 32'h7FFF_FFFF);
        add_speed(0);

        // Every register at full scale, derivative swings end to end
        add_write(CFG_TARGET_SPEED, 32767);
        add_write(CFG_GAIN_P, 32'h00FF_FFFF);
        add_write(CFG_GAIN_I, 32'h00FF_FFFF);
        add_write(CFG_GAIN_D, 32'h00FF_FFFF);
        add_write(CFG_INTEGRAL_LIMIT, 32'h7FFF_FFFF);
        add_write(CFG_DRIVE_MAX, 32767);
        add_write(CFG_DRIVE_MIN, -32768);
        add_speed(-32768);
        add_speed(32767);
        add_speed(-32768);

        // Negative target, zero integral limit, no proportional term
        add_write(CFG_TARGET_SPEED, -32768);
        add_write(CFG_INTEGRAL_LIMIT, 0);
        add_write(CFG_GAIN_P, 0);
        add_speed(32767);
        add_speed(-32768);

        // Build up the integral, then lower its limit
        add_write(CFG_TARGET_SPEED, 0);
        add_write(CFG_GAIN_I, 65536);
        add_write(CFG_GAIN_D, 0);
        add_write(CFG_INTEGRAL_LIMIT, 32'h7FFF_FFFF);
        add_write(CFG_DRIVE_MAX, 32767);
        add_write(CFG_DRIVE_MIN, -32767);
        add_speed(-30000);
        add_speed(-30000);
        add_speed(-30000);
        add_write(CFG_INTEGRAL_LIMIT, 100);
        add_speed(-30000);
        add_speed(30000);

        // Crossed drive bounds: the lower one wins
        add_write(CFG_DRIVE_MAX, -100);
        add_write(CFG_DRIVE_MIN, 100);
        add_speed(0);
        add_speed(5000);

        // Random phases, each with its own register set
        for (int ph = 0; ph < 6; ph++) begin
            case ($urandom_range(0, 7))
                0: tgt = -32768;
                1: tgt = 32767;
                2: tgt = 0;
                default: tgt = $urandom_range(0, 4000) - 2000;
            endcase
            add_write(CFG_TARGET_SPEED, tgt);
            add_write(CFG_GAIN_P, rand_gain());
            add_write(CFG_GAIN_I, rand_gain());
            add_write(CFG_GAIN_D, rand_gain());
            case ($urandom_range(0, 5))
                0: add_write(CFG_INTEGRAL_LIMIT, 0);
                1: add_write(CFG_INTEGRAL_LIMIT, 32'h7FFF_FFFF);
                default: add_write(CFG_INTEGRAL_LIMIT, $urandom_range(0, 200000));
            endcase
            case ($urandom_range(0, 7))
                0: begin
                    hi = 32767;
                    lo = -32768;
                end
                1: begin
                    hi = $urandom_range(0, 2000) - 1000;
                    lo = hi + $urandom_range(1, 500);
                end
                default: begin
                    hi = $urandom_range(0, 32767);
                    lo = -int'($urandom_range(0, 32768));
                end
            endcase
            add_write(CFG_DRIVE_MAX, hi);
            add_write(CFG_DRIVE_MIN, lo);
            if ($urandom_range(0, 2) == 0)
                add_write(CFG_UNMAPPED, $urandom);

            // Mostly samples near the target, some full range, some extremes
            repeat (300) begin
                case ($urandom_range(0, 9))
                    0: begin
                        case ($urandom_range(0, 2))
                            0: s = 32767;
                            1: s = -32768;
                            default: s = 0;
                        endcase
                    end
                    1, 2: s = int'($urandom_range(0, 65535)) - 32768;
                    default: s = tgt + int'($urandom_range(0, 200)) - 100;
                endcase
                add_speed(s);
            end
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (loop_req_q.size() != 0 || i_in_valid || i_cfg_valid
               || expected_drive_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Covered %0d speed samples and %0d register writes,", speeds_taken,
                 writes_taken);
        $display("with %0d drive results checked under random stalls.", drives_checked);
        if (fail_count == 0 && expected_drive_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
